>>> hdl/dpd_pkg.sv
// Shared types and constants for the debug packet deframer.
// Used by dpd_core and debug_packet_deframer_checksum; no dependencies.
package dpd_pkg;

  localparam logic [7:0] CH_START = 8'h24;  // '$'
  localparam logic [7:0] CH_END   = 8'h23;  // '#'
  localparam logic [7:0] CH_ESC   = 8'h7D;  // '}'
  localparam logic [7:0] ESC_XOR  = 8'h20;
  localparam logic [7:0] CH_ACK   = 8'h2B;  // '+'
  localparam logic [7:0] CH_NAK   = 8'h2D;  // '-'

  localparam int LEN_WIDTH       = 13;
  localparam int LEN_FIELD_MAX   = 8191;
  localparam int MAX_PACKET_LEN_DEFAULT = 4096;

  typedef enum logic [1:0] {
    PH_HUNT   = 2'd0,
    PH_DATA   = 2'd1,
    PH_SUM_HI = 2'd2,
    PH_SUM_LO = 2'd3
  } phase_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_END     = 1'b1
  } result_kind_t;

  typedef struct packed {
    result_kind_t         kind;
    logic [7:0]           data;
    logic                 ok;
    logic [LEN_WIDTH-1:0] len;
  } dpd_result_t;

  // Non-hex characters decode to zero.
  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) d = c - 8'h30;
    else if (c >= 8'h41 && c <= 8'h46) d = c - 8'h41 + 8'd10;
    else if (c >= 8'h61 && c <= 8'h66) d = c - 8'h61 + 8'd10;
    return d[3:0];
  endfunction

endpackage

>>> hdl/dpd_core.sv
// Framing state machine: packet phase, escape, running sum, length count.
// Depends on dpd_pkg.
module dpd_core import dpd_pkg::*; #(
  parameter int MAX_PACKET_LEN = MAX_PACKET_LEN_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        fire,
  input  logic [7:0]  rx_byte,
  output logic        res_valid,
  output dpd_result_t res
);

  localparam int LenCapInt = (MAX_PACKET_LEN < LEN_FIELD_MAX) ? MAX_PACKET_LEN : LEN_FIELD_MAX;
  localparam logic [LEN_WIDTH-1:0] LEN_CAP = LEN_WIDTH'(LenCapInt);

  phase_t               phase, phase_next;
  logic                 escape_pending, escape_pending_next;
  logic [7:0]           running_sum, running_sum_next;
  logic [3:0]           high_nibble, high_nibble_next;
  logic [LEN_WIDTH-1:0] byte_count, byte_count_next;
  logic [7:0]           unesc;
  logic                 sum_match;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT;
      escape_pending <= 1'b0;
      running_sum    <= 8'h00;
      high_nibble    <= 4'h0;
      byte_count     <= '0;
    end else if (fire) begin
      phase          <= phase_next;
      escape_pending <= escape_pending_next;
      running_sum    <= running_sum_next;
      high_nibble    <= high_nibble_next;
      byte_count     <= byte_count_next;
    end
  end

  assign unesc     = escape_pending ? (rx_byte ^ ESC_XOR) : rx_byte;
  assign sum_match = ({high_nibble, hex_value(rx_byte)} == running_sum);

  always_comb begin
    phase_next          = phase;
    escape_pending_next = escape_pending;
    running_sum_next    = running_sum;
    high_nibble_next    = high_nibble;
    byte_count_next     = byte_count;
    res_valid           = 1'b0;
    res                 = '{kind: KIND_PAYLOAD, data: unesc, ok: 1'b0, len: byte_count};
    unique case (phase)
      PH_HUNT: begin
        if (rx_byte == CH_START) begin
          phase_next          = PH_DATA;
          escape_pending_next = 1'b0;
          running_sum_next    = 8'h00;
          high_nibble_next    = 4'h0;
          byte_count_next     = '0;
        end
      end
      PH_DATA: begin
        // '#' ends the payload even when an escape is pending
        if (rx_byte == CH_END) begin
          phase_next = PH_SUM_HI;
        end else begin
          running_sum_next = running_sum + rx_byte;
          if (rx_byte == CH_ESC && !escape_pending) begin
            escape_pending_next = 1'b1;
          end else begin
            escape_pending_next = 1'b0;
            if (byte_count < LEN_CAP) byte_count_next = byte_count + 1'b1;
            res_valid = 1'b1;
            res.len   = byte_count_next;
          end
        end
      end
      PH_SUM_HI: begin
        high_nibble_next = hex_value(rx_byte);
        phase_next       = PH_SUM_LO;
      end
      PH_SUM_LO: begin
        phase_next = PH_HUNT;
        res_valid  = 1'b1;
        res.kind   = KIND_END;
        res.data   = sum_match ? CH_ACK : CH_NAK;
        res.ok     = sum_match;
      end
      default: phase_next = PH_HUNT;
    endcase
  end

  a_len_capped: assert property (@(posedge clk) disable iff (rst)
    byte_count <= LEN_CAP)
    else $error("payload length beyond cap");

  a_end_returns_hunt: assert property (@(posedge clk) disable iff (rst)
    fire && phase == PH_SUM_LO |=> phase == PH_HUNT && !$stable(phase))
    else $error("packet end did not return to hunt");

  a_esc_only_in_data: assert property (@(posedge clk) disable iff (rst)
    fire && escape_pending_next && !escape_pending |-> phase == PH_DATA)
    else $error("escape set outside payload");

endmodule

>>> hdl/debug_packet_deframer_checksum.sv
// Top level of the debug packet deframer: input register, dpd_core, result register.
// Depends on dpd_pkg and dpd_core.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------------
//  in      | in_valid / in_stall  | rx_byte
//  out     | out_valid / out_stall| result_kind, data_byte, checksum_ok, payload_length
//
// One word per cycle sustained while the output is not stalled.
// Each word is registered, decoded by the framing logic, and its
// result (if any) registered. Synchronous reset returns to hunting for '$'.
// A stalled output holds the result register and backs up into the input register.
module debug_packet_deframer_checksum import dpd_pkg::*; #(
  parameter int MAX_PACKET_LEN = MAX_PACKET_LEN_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           rx_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 result_kind,
  output logic [7:0]           data_byte,
  output logic                 checksum_ok,
  output logic [LEN_WIDTH-1:0] payload_length
);

  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_adv;
  logic        fire;
  logic        res_valid;
  dpd_result_t res;
  dpd_result_t out_res;

  assign s1_adv   = !out_valid || !out_stall;
  assign in_stall = s1_valid && !s1_adv;
  assign fire     = s1_valid && s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) s1_byte <= rx_byte;
  end

  dpd_core #(
    .MAX_PACKET_LEN(MAX_PACKET_LEN)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .rx_byte  (s1_byte),
    .res_valid(res_valid),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= fire && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_valid) out_res <= res;
  end

  assign result_kind    = out_res.kind;
  assign data_byte      = out_res.data;
  assign checksum_ok    = out_res.ok;
  assign payload_length = out_res.len;

endmodule

>>> tb/sv/debug_packet_deframer_checksum_test.sv
// Self-checking testbench for debug_packet_deframer_checksum: directed table, then random
// packets and noise, checked against a behavioral deframer. Depends on dpd_pkg.
`timescale 1ns / 1ps

module debug_packet_deframer_checksum_test;
  import dpd_pkg::*;

  localparam int LEN_CAP = (MAX_PACKET_LEN_DEFAULT < LEN_FIELD_MAX) ?
                           MAX_PACKET_LEN_DEFAULT : LEN_FIELD_MAX;
  localparam int RANDOM_ITEMS = 1300;
  localparam int IDLE_LIMIT = 4000;

  // One input word plus, on typed rows, the expected outcome written out by hand.
  typedef struct packed {
    logic [7:0]           rx;
    logic                 typed;
    logic                 has;
    result_kind_t         kind;
    logic [7:0]           data;
    logic                 ok;
    logic [LEN_WIDTH-1:0] len;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 25;
  localparam stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{8'h00,    1'b1, 1'b0, KIND_PAYLOAD, 8'h00,    1'b0, 13'd0}, // ignored while hunting
    '{CH_START, 1'b1, 1'b0, KIND_PAYLOAD, 8'h00,    1'b0, 13'd0},
    '{CH_END,   1'b1, 1'b0, KIND_PAYLOAD, 8'h00,    1'b0, 13'd0},
    '{"0",      1'b1, 1'b0, KIND_PAYLOAD, 8'h00,    1'b0, 13'd0},
    '{"0",      1'b1, 1'b1, KIND_END,     CH_ACK,   1'b1, 13'd0}, // empty packet
    '{CH_START, 1'b1, 1'b0, KIND_PAYLOAD, 8'h00,    1'b0, 13'd0},
    '{8'h00,    1'b1, 1'b1, KIND_PAYLOAD, 8'h00,    1'b0, 13'd1},
    '{8'hFF,    1'b1, 1'b1, KIND_PAYLOAD, 8'hFF,    1'b0, 13'd2},
    '{CH_START, 1'b1, 1'b1, KIND_PAYLOAD, CH_START, 1'b0, 13'd3}, // '$' is plain data here
    '{CH_ESC,   1'b1, 1'b0, KIND_PAYLOAD, 8'h00,    1'b0, 13'd0},
    '{CH_ESC,   1'b0, 1'b0, KIND_PAYLOAD, 8'h00,    1'b0, 13'd0}, // double escape
    '{CH_ESC,   1'b1, 1'b0, KIND_PAYLOAD, 8'h00,    1'b0, 13'd0},
    '{CH_END,   1'b1, 1'b0, KIND_PAYLOAD, 8'h00,    1'b0, 13'd0}, // escaped '#' still ends
    '{"z",      1'b0, 1'b0, KIND_PAYLOAD, 8'h00,    1'b0, 13'd0}, // non-hex digits read as 0
    '{"G",      1'b1, 1'b1, KIND_END,     CH_NAK,   1'b0, 13'd4},
    '{CH_START, 1'b0, 1'b0, KIND_PAYLOAD, 8'h00,    1'b0, 13'd0}, // drops stale escape
    '{8'hAF,    1'b0, 1'b0, KIND_PAYLOAD, 8'h00,    1'b0, 13'd0},
    '{CH_END,   1'b0, 1'b0, KIND_PAYLOAD, 8'h00,    1'b0, 13'd0},
    '{"a",      1'b0, 1'b0, KIND_PAYLOAD, 8'h00,    1'b0, 13'd0},
    '{"f",      1'b1, 1'b1, KIND_END,     CH_ACK,   1'b1, 13'd1},
    '{CH_START, 1'b0, 1'b0, KIND_PAYLOAD, 8'h00,    1'b0, 13'd0},
    '{8'h4E,    1'b0, 1'b0, KIND_PAYLOAD, 8'h00,    1'b0, 13'd0},
    '{CH_END,   1'b0, 1'b0, KIND_PAYLOAD, 8'h00,    1'b0, 13'd0},
    '{"4",      1'b0, 1'b0, KIND_PAYLOAD, 8'h00,    1'b0, 13'd0},
    '{"E",      1'b1, 1'b1, KIND_END,     CH_ACK,   1'b1, 13'd1}
  };

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic [7:0]           rx_byte;
  logic                 out_valid;
  logic                 out_stall;
  logic                 result_kind;
  logic [7:0]           data_byte;
  logic                 checksum_ok;
  logic [LEN_WIDTH-1:0] payload_length;

  debug_packet_deframer_checksum #(
    .MAX_PACKET_LEN(MAX_PACKET_LEN_DEFAULT)
  ) dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .result_kind    (result_kind),
    .data_byte      (data_byte),
    .checksum_ok    (checksum_ok),
    .payload_length (payload_length)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  stim_row_t    rx_stream [$];
  dpd_result_t  pending_results [$];
  stim_row_t    cur_row;
  stim_row_t    next_row;
  int           error_count;
  int           idle_cycles;
  int           burst_left;
  int           gap_left;
  int           stall_mode;
  int           stall_timer;
  int unsigned  cycle_count;

  // Behavioral deframer state
  phase_t               ph;
  logic                 esc_pending;
  logic [7:0]           frame_sum;
  logic [3:0]           sum_hi;
  logic [LEN_WIDTH-1:0] frame_len;

  function automatic logic [3:0] digit_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return 4'(c - "0");
    if (c >= "A" && c <= "F") return 4'(c - "A" + 10);
    if (c >= "a" && c <= "f") return 4'(c - "a" + 10);
    return 4'd0;
  endfunction

  function automatic logic [7:0] digit_char(input logic [3:0] n);
    if (n < 10) return 8'("0" + n);
    return 8'(($urandom_range(0, 1) ? "A" : "a") + n - 10);
  endfunction

  // Advances the deframer by one received word; returns 1 when a result is produced.
  function automatic bit deframe_byte(input logic [7:0] b, output dpd_result_t r);
    logic [7:0] d;
    d = b;
    r = '0;
    case (ph)
      PH_HUNT: begin
        if (b == CH_START) begin
          ph = PH_DATA;
          esc_pending = 1'b0;
          frame_sum = 8'h00;
          sum_hi = 4'h0;
          frame_len = '0;
        end
        return 1'b0;
      end
      PH_DATA: begin
        if (b == CH_END) begin
          ph = PH_SUM_HI;
          return 1'b0;
        end
        frame_sum = frame_sum + b;
        if (b == CH_ESC && !esc_pending) begin
          esc_pending = 1'b1;
          return 1'b0;
        end
        if (esc_pending) begin
          esc_pending = 1'b0;
          d = b ^ ESC_XOR;
        end
        if (frame_len < LEN_CAP) frame_len = frame_len + 1'b1;
        r.kind = KIND_PAYLOAD;
        r.data = d;
        r.ok = 1'b0;
        r.len = frame_len;
        return 1'b1;
      end
      PH_SUM_HI: begin
        sum_hi = digit_value(b);
        ph = PH_SUM_LO;
        return 1'b0;
      end
      default: begin
        ph = PH_HUNT;
        r.kind = KIND_END;
        r.ok = ({sum_hi, digit_value(b)} == frame_sum);
        r.data = r.ok ? CH_ACK : CH_NAK;
        r.len = frame_len;
        return 1'b1;
      end
    endcase
  endfunction

  task automatic push_raw(input logic [7:0] b);
    stim_row_t row;
    row = '0;
    row.rx = b;
    row.kind = KIND_PAYLOAD;
    rx_stream.push_back(row);
  endtask

  // Frames n data words. corrupt spoils the checksum; dangling_esc leaves '}' before '#'.
  task automatic push_packet(input int n, input bit corrupt, input bit dangling_esc);
    logic [7:0] d;
    logic [7:0] csum;
    logic [7:0] special [3];
    special = '{CH_START, CH_END, CH_ESC};
    csum = 8'h00;
    push_raw(CH_START);
    for (int i = 0; i < n; i++) begin
      d = 8'($urandom);
      if ($urandom_range(0, 15) == 0) d = special[$urandom_range(0, 2)];
      // an escaped 0x03 would arrive as '#', so that one always goes out raw
      if ((d == CH_END || d == CH_ESC || $urandom_range(0, 9) == 0) && d != (CH_END ^ ESC_XOR))
      begin
        push_raw(CH_ESC);
        push_raw(d ^ ESC_XOR);
        csum = csum + CH_ESC + (d ^ ESC_XOR);
      end else begin
        push_raw(d);
        csum = csum + d;
      end
    end
    if (dangling_esc) begin
      push_raw(CH_ESC);
      csum = csum + CH_ESC;
    end
    push_raw(CH_END);
    if (corrupt && $urandom_range(0, 1)) begin
      push_raw(8'($urandom));
      push_raw(8'($urandom));
    end else begin
      if (corrupt) csum = csum ^ (8'h01 << $urandom_range(0, 7));
      push_raw(digit_char(csum[7:4]));
      push_raw(digit_char(csum[3:0]));
    end
  endtask

  task automatic build_stimulus();
    int counted;
    int pick;
    int mark;
    counted = 0;
    foreach (directed_rows[i]) rx_stream.push_back(directed_rows[i]);
    while (counted < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      mark = rx_stream.size();
      if (pick < 8) begin
        for (int i = $urandom_range(1, 5); i > 0; i--) push_raw(8'($urandom));
      end else if (pick < 18) begin
        push_packet($urandom_range(0, 6), $urandom_range(0, 1), 1'b1);
      end else if (pick < 30) begin
        push_packet($urandom_range(0, 12), 1'b1, 1'b0);
      end else if (pick < 35) begin
        // packet cut off before its '#'; what follows is taken as payload
        push_raw(CH_START);
        for (int i = $urandom_range(0, 4); i > 0; i--) push_raw(8'($urandom));
      end else begin
        push_packet($urandom_range(0, 24), 1'b0, 1'b0);
      end
      counted += rx_stream.size() - mark;
    end
  endtask

  task automatic take_word(input stim_row_t row);
    dpd_result_t r;
    bit has;
    has = deframe_byte(row.rx, r);
    if (row.typed) begin
      has = row.has;
      r.kind = row.kind;
      r.data = row.data;
      r.ok = row.ok;
      r.len = row.len;
    end
    if (has) pending_results.push_back(r);
  endtask

  task automatic check_result();
    dpd_result_t e;
    if (pending_results.size() == 0) begin
      $error("unexpected result: kind %0d data %h ok %0d len %0d",
             result_kind, data_byte, checksum_ok, payload_length);
      error_count++;
      return;
    end
    e = pending_results.pop_front();
    if (result_kind !== e.kind) begin
      $error("result_kind: expected %0d, got %0d", e.kind, result_kind);
      error_count++;
    end
    if (data_byte !== e.data) begin
      $error("data_byte: expected %h, got %h", e.data, data_byte);
      error_count++;
    end
    if (checksum_ok !== e.ok) begin
      $error("checksum_ok: expected %0d, got %0d", e.ok, checksum_ok);
      error_count++;
    end
    if (payload_length !== e.len) begin
      $error("payload_length: expected %0d, got %0d", e.len, payload_length);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      out_stall <= 1'b0;
      idle_cycles <= 0;
      burst_left <= 1;
      gap_left <= 0;
      stall_mode <= 0;
      stall_timer <= 0;
      cycle_count <= 0;
    end else begin
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end else begin
        cycle_count <= cycle_count + 1;
        if (out_valid && !out_stall) check_result();
        if (in_valid && !in_stall) take_word(cur_row);
        if ((out_valid && !out_stall) || (in_valid && !in_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;

        // sender: bursts with random gaps; a stalled word is held
        if (!in_valid || !in_stall) begin
          if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            in_valid <= 1'b0;
          end else if (rx_stream.size() > 0) begin
            next_row = rx_stream.pop_front();
            cur_row <= next_row;
            rx_byte <= next_row.rx;
            in_valid <= 1'b1;
            if (burst_left <= 1) begin
              burst_left <= $urandom_range(1, 48);
              gap_left <= $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 12);
            end else begin
              burst_left <= burst_left - 1;
            end
          end else begin
            in_valid <= 1'b0;
          end
        end

        // receiver: stall pattern switches among none, light, heavy and periodic
        if (stall_timer == 0) begin
          stall_mode <= $urandom_range(0, 3);
          stall_timer <= $urandom_range(20, 200);
        end else begin
          stall_timer <= stall_timer - 1;
        end
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= cycle_count[2];
        endcase
      end
    end
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    out_stall = 1'b0;
    rx_byte = 8'h00;
    cur_row = '0;
    error_count = 0;
    ph = PH_HUNT;
    esc_pending = 1'b0;
    frame_sum = 8'h00;
    sum_hi = 4'h0;
    frame_len = '0;
    build_stimulus();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    while (rx_stream.size() > 0 || in_valid || pending_results.size() > 0) @(negedge clk);
    // let any stray word surface before the verdict
    repeat (20) @(negedge clk);
    if (error_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> files.f
hdl/dpd_pkg.sv
hdl/dpd_core.sv
hdl/debug_packet_deframer_checksum.sv
tb/sv/debug_packet_deframer_checksum_test.sv
